// ----- sv/lbse_pkg.sv -----
// Shared types and constants of the LED bar scanning eye.
// Used by the front end, the tick queue, the render back end and the top level.
package lbse_pkg;

  localparam int unsigned NumLeds   = 9;
  localparam int unsigned NumParts  = 5;
  localparam int unsigned PosW      = 8;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned FracW     = 4;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 72;

  // Position limits of the scan.
  localparam logic [PosW-1:0] ScanWrap    = 8'd240;
  localparam logic [PosW-1:0] SoftLimit   = 8'd224;
  localparam logic [PosW-1:0] SoftRestart = 8'd15;
  localparam logic [PosW-1:0] EyeOffset   = 8'd15;
  localparam logic [11:0]     LeftCenter  = 12'd127;
  localparam logic [PosW-1:0] PassBase    = 8'd10;
  localparam logic [PosW-1:0] LastLed     = 8'd8;
  localparam logic [PosW-1:0] TickReset   = 8'd254;

  typedef enum logic [CfgIndexW-1:0] {
    RegStepDivider = 3'd0,
    RegDoubleSpeed = 3'd1,
    RegSoftBounce  = 3'd2,
    RegLeftEnd     = 3'd3,
    RegRightEnd    = 3'd4
  } lbse_reg_e;

  typedef struct packed {
    logic [7:0] step_divider;
    logic       double_speed;
    logic       soft_bounce;
    logic       left_end;
    logic       right_end;
  } lbse_cfg_t;

  // One classified tick as it travels from the front end to the back end.
  typedef struct packed {
    logic is_step;
    logic button_pressed;
    logic start_from_left;
    logic start_from_right;
  } lbse_tick_t;

  typedef logic [LevelW-1:0] lbse_level_t;

  // Weight of each eye part; the last part only carries the trailing share.
  function automatic logic [2:0] part_weight(input int unsigned idx);
    logic [2:0] w;
    case (idx)
      0:       w = 3'd4;
      1:       w = 3'd2;
      2:       w = 3'd1;
      3:       w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/led_bar_scanning_eye_top.sv -----
// Top level of the LED bar scanning eye: configuration registers and the
// front end, tick queue and back end. Depends on lbse_pkg and all lbse_ modules.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid_i/s_axis_tready_o one tick: button and triggers
//   m_axis    out        m_axis_tvalid_o/m_axis_tready_i nine LED levels, hand-offs, running
//   cfg       in         cfg_valid_i/cfg_ready_o         register index and write data
//
// While the queue has room, one tick transaction is taken per clock, and while the
// receiver is ready, one result transaction leaves per clock. A tick is written into
// the queue, the render stage works on it as it leaves the queue, and the output
// register loads the result.
// Reset clears the prescaler to 254, the scan state, the LED levels and the queue,
// and loads the configuration defaults. A stalled output holds its result while the
// queue keeps taking ticks until it fills; the configuration port never stalls.
module led_bar_scanning_eye_top import lbse_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Tick stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Bits from low up: button_pressed, start_from_left, start_from_right, zero fill.
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // Result stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Bits from low up: bright_0 .. bright_8 (7 bits each), pass_right, pass_left,
  // running, zero fill.
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  lbse_cfg_t  cfg_q, cfg_d;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  lbse_tick_t q_in;
  lbse_tick_t q_out;

  // Always writable; software must write only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (lbse_reg_e'(cfg_index_i))
        RegStepDivider: cfg_d.step_divider = cfg_data_i;
        RegDoubleSpeed: cfg_d.double_speed = cfg_data_i[0];
        RegSoftBounce:  cfg_d.soft_bounce  = cfg_data_i[0];
        RegLeftEnd:     cfg_d.left_end     = cfg_data_i[0];
        RegRightEnd:    cfg_d.right_end    = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_divider <= '0;
      cfg_q.double_speed <= 1'b1;
      cfg_q.soft_bounce  <= 1'b0;
      cfg_q.left_end     <= 1'b0;
      cfg_q.right_end    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end tags each tick as an animation step or a hold tick.
  lbse_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  // The queue lets the input side keep going while the output side stalls.
  lbse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  // The back end moves the eye, renders the LEDs and holds the result register.
  lbse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- sv/lbse_front.sv -----
// Front end of the LED bar scanning eye: takes input transactions, runs the
// step prescaler and tags each tick as step or hold. Depends on lbse_pkg.
module lbse_front import lbse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbse_cfg_t           cfg_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InTdataW-1:0] s_axis_tdata_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output lbse_tick_t          q_entry_o
);

  logic [PosW-1:0] tick_count_q, tick_count_d;
  logic [PosW-1:0] tick_inc;
  logic            is_step;

  assign s_axis_tready_o = ~q_full_i;
  assign q_push_o        = s_axis_tvalid_i & ~q_full_i;

  always_comb begin
    tick_inc     = tick_count_q + 8'd1;
    is_step      = tick_inc > cfg_i.step_divider;
    tick_count_d = tick_count_q;
    if (q_push_o) begin
      tick_count_d = is_step ? '0 : tick_inc;
    end
  end

  always_comb begin
    q_entry_o.is_step          = is_step;
    q_entry_o.button_pressed   = s_axis_tdata_i[0];
    q_entry_o.start_from_left  = s_axis_tdata_i[1];
    q_entry_o.start_from_right = s_axis_tdata_i[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= TickReset;
    end else begin
      tick_count_q <= tick_count_d;
    end
  end

endmodule

// ----- sv/lbse_queue.sv -----
// Short queue of classified ticks between the front end and the back end.
// Depends on lbse_pkg for the entry type.
module lbse_queue import lbse_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lbse_tick_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  output lbse_tick_t entry_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lbse_tick_t      slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign entry_o = slots_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- sv/lbse_back.sv -----
// Back end of the LED bar scanning eye: scan state, eye render and the
// registered result stage. Depends on lbse_pkg.
module lbse_back import lbse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbse_cfg_t            cfg_i,
  input  logic                 q_valid_i,
  input  lbse_tick_t           q_entry_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  // Scan state.
  logic [PosW-1:0] scan_position_q, scan_position_d;
  logic            moving_left_q, moving_left_d;
  logic            active_q, active_d;
  logic            started_once_q, started_once_d;
  lbse_level_t     levels_q [NumLeds];
  lbse_level_t     levels_d [NumLeds];

  // Result stage.
  logic            out_valid_q;
  lbse_level_t     bright_q [NumLeds];
  lbse_level_t     bright_d [NumLeds];
  logic            pass_right_q, pass_right_d;
  logic            pass_left_q, pass_left_d;
  logic            running_q;

  assign q_pop_o = q_valid_i & (~out_valid_q | m_axis_tready_i);

  always_comb begin
    logic                   act1, act2, ml1, ml2, ml3, soft1, soft2;
    logic [PosW-1:0]        pos_a, pos_b, pos_c, base, v;
    logic [11:0]            d;
    logic [FracW-1:0]       rw, mw;
    logic signed [PosW-1:0] m;
    logic [3:0]             loc [NumParts];
    logic                   lit [NumParts];
    lbse_level_t            contrib [NumParts];
    lbse_level_t            acc;
    logic                   pl;

    scan_position_d = scan_position_q;
    moving_left_d   = moving_left_q;
    active_d        = active_q;
    started_once_d  = started_once_q;
    levels_d        = levels_q;
    pass_right_d    = 1'b0;
    pass_left_d     = 1'b0;

    act1  = active_q;
    ml1   = moving_left_q;
    act2  = 1'b0;
    ml2   = 1'b0;
    ml3   = 1'b0;
    soft1 = 1'b0;
    soft2 = 1'b0;
    pos_a = '0;
    pos_b = '0;
    pos_c = '0;
    base  = '0;
    v     = '0;
    d     = '0;
    rw    = '0;
    mw    = '0;
    m     = '0;
    acc   = '0;
    pl    = 1'b0;
    for (int p = 0; p < NumParts; p++) begin
      loc[p]     = '0;
      lit[p]     = 1'b0;
      contrib[p] = '0;
    end

    if (q_entry_i.is_step) begin
      // Triggers are sampled on every step, running or not.
      if (q_entry_i.button_pressed && cfg_i.left_end && !started_once_q) begin
        act1           = 1'b1;
        started_once_d = 1'b1;
      end
      if (q_entry_i.start_from_left) begin
        ml1  = 1'b0;
        act1 = 1'b1;
      end
      if (q_entry_i.start_from_right) begin
        ml1  = 1'b1;
        act1 = 1'b1;
      end
      moving_left_d = ml1;
      active_d      = act1;

      if (act1) begin
        pos_a = scan_position_q + (cfg_i.double_speed ? 8'd2 : 8'd1);
        soft1 = cfg_i.soft_bounce &
                ((~ml1 & cfg_i.right_end) | (ml1 & cfg_i.left_end));
        if (soft1 && pos_a >= SoftLimit) begin
          pos_b = SoftRestart;
          ml2   = ~ml1;
        end else begin
          pos_b = pos_a;
          ml2   = ml1;
        end
        act2 = 1'b1;
        if (pos_b >= ScanWrap) begin
          // Reaching the far end reverses; an end that hands over stops.
          pos_c = '0;
          ml3   = ~ml2;
          act2  = ml2 ? cfg_i.left_end : cfg_i.right_end;
        end else begin
          pos_c = pos_b;
          ml3   = ml2;
        end

        // Base LED and the split of the eye between neighboring LEDs.
        if (!ml3) begin
          v    = EyeOffset + pos_c;
          base = {4'b0, v[7:4]};
          rw   = v[3:0];
          mw   = ~rw;
        end else begin
          d    = LeftCenter - {4'b0, pos_c};
          base = d[11:4];
          mw   = d[3:0];
          rw   = ~mw;
        end

        soft2 = cfg_i.soft_bounce &
                ((~ml3 & cfg_i.right_end) | (ml3 & cfg_i.left_end));

        for (int p = 0; p < NumParts; p++) begin
          m = ml3 ? $signed(base + 8'(p + 1)) : $signed(base - 8'(p + 1));
          if (soft2) begin
            // Parts that run past the bar end pile up on the end LED.
            if (!ml3 && m > $signed(LastLed)) m = $signed(LastLed);
            if (ml3 && m < 8'sd0) m = 8'sd0;
          end else if (m == -8'sd1 && ml3 && !cfg_i.left_end) begin
            pl = 1'b1;
          end
          lit[p] = (m >= 8'sd0) && (m <= $signed(LastLed));
          loc[p] = m[3:0];
        end

        for (int p = 0; p < NumParts; p++) begin
          contrib[p] = '0;
          if (p < NumParts - 1) begin
            contrib[p] = contrib[p] + 7'(part_weight(p)) * 7'(rw);
          end
          if (p > 0) begin
            contrib[p] = contrib[p] + 7'(part_weight(p - 1)) * 7'(mw);
          end
        end

        for (int j = 0; j < NumLeds; j++) begin
          acc = '0;
          for (int p = 0; p < NumParts; p++) begin
            if (lit[p] && loc[p] == 4'(j)) acc = acc + contrib[p];
          end
          levels_d[j] = acc;
        end

        scan_position_d = pos_c;
        moving_left_d   = ml3;
        active_d        = act2;
        pass_right_d    = (base == PassBase) & ~ml3 & ~cfg_i.right_end;
        pass_left_d     = pl;
      end
    end

    for (int j = 0; j < NumLeds; j++) begin
      bright_d[j] = active_d ? levels_d[j] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_position_q <= '0;
      moving_left_q   <= 1'b0;
      active_q        <= 1'b0;
      started_once_q  <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int j = 0; j < NumLeds; j++) begin
        levels_q[j] <= '0;
      end
    end else begin
      if (q_pop_o) begin
        scan_position_q <= scan_position_d;
        moving_left_q   <= moving_left_d;
        active_q        <= active_d;
        started_once_q  <= started_once_d;
        levels_q        <= levels_d;
        out_valid_q     <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bright_q     <= bright_d;
      pass_right_q <= pass_right_d;
      pass_left_q  <= pass_left_d;
      running_q    <= active_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    m_axis_tdata_o = '0;
    for (int j = 0; j < NumLeds; j++) begin
      m_axis_tdata_o[j*LevelW +: LevelW] = bright_q[j];
    end
    m_axis_tdata_o[NumLeds*LevelW]     = pass_right_q;
    m_axis_tdata_o[NumLeds*LevelW + 1] = pass_left_q;
    m_axis_tdata_o[NumLeds*LevelW + 2] = running_q;
  end

  // The position never rests at or beyond the wrap point.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_position_q < ScanWrap)
    else $error("scan position out of range");

  // A hold tick leaves position and direction alone.
  a_hold_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !q_entry_i.is_step |=> $stable(scan_position_q) && $stable(moving_left_q))
    else $error("hold tick moved the eye");

  // The button start is a one-shot until the next reset.
  a_started_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(started_once_q))
    else $error("started flag cleared without reset");

  // Hand-off toward both neighbors at once cannot happen.
  a_single_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(pass_right_q && pass_left_q))
    else $error("hand-off pulsed in both directions");

  // A stopped unit shows no light.
  a_dark_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !running_q |-> m_axis_tdata_o[NumLeds*LevelW-1:0] == '0)
    else $error("stopped unit lit an LED");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for led_bar_scanning_eye_top: drives tick and register traffic
// and checks every result frame against a built-in scanner model. Depends on lbse_pkg.
module tb;
  import lbse_pkg::*;

  // Receiver back-pressure styles, chosen per phase.
  typedef enum int {
    ReadyAlways,
    ReadyRandom,
    ReadyPeriodic,
    ReadyLongStall
  } ready_style_e;

  // One result frame as the block reports it.
  typedef struct packed {
    logic [NumLeds-1:0][LevelW-1:0] bright;
    logic                           pass_right;
    logic                           pass_left;
    logic                           running;
  } eye_frame_t;

  // Scan geometry, kept separate from the design's own constants.
  localparam logic [7:0]  WrapPos      = 8'd240;
  localparam logic [7:0]  SoftPos      = 8'd224;
  localparam logic [7:0]  SoftReentry  = 8'd15;
  localparam logic [11:0] LeftPivot    = 12'd127;
  localparam logic [7:0]  HandOffBase  = 8'd10;
  localparam int          MaxReports   = 10;
  localparam int          DrainLimit   = 4000;
  localparam int          IdlePause    = 4;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  led_bar_scanning_eye_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state: prescaler, scan position and direction, run flags and LED levels.
  lbse_cfg_t  reg_mirror = '{step_divider: 8'd0, double_speed: 1'b1, soft_bounce: 1'b0,
                             left_end: 1'b0, right_end: 1'b0};
  logic [7:0] tick_ctr = 8'd254;
  logic [7:0] scan_pos = 8'd0;
  logic       heading_left = 1'b0;
  logic       scanning = 1'b0;
  logic       started_flag = 1'b0;
  logic [LevelW-1:0] led_level [NumLeds];

  eye_frame_t   pending_frames [$];
  int           failures = 0;
  int           burst_left = 0;
  logic         quiet_sender = 1'b0;
  ready_style_e ready_style = ReadyAlways;
  int           stall_hold = 0;
  int unsigned  cycle_ctr = 0;
  eye_frame_t   got_frame;
  eye_frame_t   want_frame;

  initial begin
    for (int k = 0; k < NumLeds; k++) led_level[k] = '0;
  end

  // Advances the scanner model by one tick and returns the frame it should report.
  function automatic eye_frame_t advance_eye(input logic btn, input logic from_l,
                                             input logic from_r);
    eye_frame_t        f;
    logic [7:0]        base;
    logic [3:0]        near_w;
    logic [3:0]        far_w;
    logic [8:0]        right_sum;
    logic [11:0]       left_sum;
    logic              bounce_on;
    logic signed [7:0] idx8;
    int                loc [NumParts];
    int                acc [NumLeds];
    int                wt;
    f = '0;
    tick_ctr = tick_ctr + 8'd1;
    if (tick_ctr > reg_mirror.step_divider) begin
      tick_ctr = 8'd0;
      if (btn && reg_mirror.left_end && !started_flag) begin
        scanning = 1'b1;
        started_flag = 1'b1;
      end
      if (from_l) begin
        heading_left = 1'b0;
        scanning = 1'b1;
      end
      if (from_r) begin
        heading_left = 1'b1;
        scanning = 1'b1;
      end
      if (scanning) begin
        scan_pos = scan_pos + 8'd1 + {7'd0, reg_mirror.double_speed};
        bounce_on = reg_mirror.soft_bounce && ((!heading_left && reg_mirror.right_end) ||
                                               (heading_left && reg_mirror.left_end));
        if (bounce_on && scan_pos >= SoftPos) begin
          scan_pos = SoftReentry;
          heading_left = !heading_left;
        end
        if (scan_pos >= WrapPos) begin
          scan_pos = 8'd0;
          if (!heading_left) begin
            heading_left = 1'b1;
            if (!reg_mirror.right_end) scanning = 1'b0;
          end else begin
            heading_left = 1'b0;
            if (!reg_mirror.left_end) scanning = 1'b0;
          end
        end
        // Split the position into an LED base index and the sub-LED share.
        if (!heading_left) begin
          right_sum = 9'd15 + {1'b0, scan_pos};
          base = {4'd0, right_sum[7:4]};
          near_w = right_sum[3:0];
          far_w = 4'd15 - near_w;
        end else begin
          left_sum = LeftPivot - {4'd0, scan_pos};
          base = left_sum[11:4];
          far_w = left_sum[3:0];
          near_w = 4'd15 - far_w;
        end
        if (base == HandOffBase && !heading_left && !reg_mirror.right_end)
          f.pass_right = 1'b1;
        bounce_on = reg_mirror.soft_bounce && ((!heading_left && reg_mirror.right_end) ||
                                               (heading_left && reg_mirror.left_end));
        for (int i = 0; i < NumParts; i++) begin
          if (heading_left) idx8 = base + 8'(i + 1);
          else idx8 = base - 8'(i + 1);
          loc[i] = idx8;
          if (bounce_on) begin
            // At a chain end the eye piles up on the outermost LED instead of leaving.
            if (!heading_left && loc[i] > 8) loc[i] = 8;
            if (heading_left && loc[i] < 0) loc[i] = 0;
            if (loc[i] > 8) loc[i] = -1;
          end else begin
            if (loc[i] == -1 && heading_left && !reg_mirror.left_end) f.pass_left = 1'b1;
            if (loc[i] > 8 || loc[i] < 0) loc[i] = -1;
          end
        end
        for (int k = 0; k < NumLeds; k++) acc[k] = 0;
        for (int i = 0; i < NumParts - 1; i++) begin
          wt = (i == 0) ? 4 : ((i == 1) ? 2 : 1);
          if (loc[i] >= 0) acc[loc[i]] += wt * int'(near_w);
          if (loc[i + 1] >= 0) acc[loc[i + 1]] += wt * int'(far_w);
        end
        for (int k = 0; k < NumLeds; k++) led_level[k] = acc[k][LevelW-1:0];
      end
    end
    for (int k = 0; k < NumLeds; k++) f.bright[k] = scanning ? led_level[k] : '0;
    f.running = scanning;
    return f;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Receiver side: each phase picks one back-pressure style.
  always @(posedge clk_i) begin
    cycle_ctr <= cycle_ctr + 1;
    case (ready_style)
      ReadyAlways: begin
        m_axis_tready_i <= 1'b1;
      end
      ReadyRandom: begin
        m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      end
      ReadyPeriodic: begin
        m_axis_tready_i <= ((cycle_ctr % 13) < 8);
      end
      default: begin
        if (stall_hold != 0) begin
          stall_hold <= stall_hold - 1;
          m_axis_tready_i <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          stall_hold <= $urandom_range(5, 30);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    endcase
  end

  // Result checker: each result transaction is matched to the oldest pending frame.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      for (int k = 0; k < NumLeds; k++)
        got_frame.bright[k] = m_axis_tdata_o[LevelW*k +: LevelW];
      got_frame.pass_right = m_axis_tdata_o[NumLeds*LevelW];
      got_frame.pass_left = m_axis_tdata_o[NumLeds*LevelW + 1];
      got_frame.running = m_axis_tdata_o[NumLeds*LevelW + 2];
      if (pending_frames.size() == 0) begin
        note_failure($sformatf("result %h arrived with no tick pending", m_axis_tdata_o));
      end else begin
        want_frame = pending_frames.pop_front();
        for (int k = 0; k < NumLeds; k++)
          if (got_frame.bright[k] !== want_frame.bright[k])
            note_failure($sformatf("bright_%0d expected %0d got %0d", k,
                                   want_frame.bright[k], got_frame.bright[k]));
        if (got_frame.pass_right !== want_frame.pass_right)
          note_failure($sformatf("pass_right expected %b got %b",
                                 want_frame.pass_right, got_frame.pass_right));
        if (got_frame.pass_left !== want_frame.pass_left)
          note_failure($sformatf("pass_left expected %b got %b",
                                 want_frame.pass_left, got_frame.pass_left));
        if (got_frame.running !== want_frame.running)
          note_failure($sformatf("running expected %b got %b",
                                 want_frame.running, got_frame.running));
      end
    end
  end

  // Sends one tick transaction. Ticks go out in bursts with random gaps in between;
  // tvalid stays high from one tick to the next inside a burst.
  task automatic send_tick(input logic btn, input logic from_l, input logic from_r);
    int gap;
    if (burst_left == 0) begin
      gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'd0, from_r, from_l, btn};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_frames.push_back(advance_eye(btn, from_l, from_r));
  endtask

  // Stops the tick stream and waits until every pending frame has come back.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic write_reg(input lbse_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegStepDivider: reg_mirror.step_divider = val;
      RegDoubleSpeed: reg_mirror.double_speed = val[0];
      RegSoftBounce:  reg_mirror.soft_bounce = val[0];
      RegLeftEnd:     reg_mirror.left_end = val[0];
      default:        reg_mirror.right_end = val[0];
    endcase
  endtask

  // Rewrites every register on an idle block and picks new receiver and sender styles.
  task automatic configure(input logic [7:0] div, input logic dbl, input logic bnc,
                           input logic le, input logic re);
    settle();
    write_reg(RegStepDivider, div);
    write_reg(RegDoubleSpeed, {7'd0, dbl});
    write_reg(RegSoftBounce, {7'd0, bnc});
    write_reg(RegLeftEnd, {7'd0, le});
    write_reg(RegRightEnd, {7'd0, re});
    cfg_valid_i <= 1'b0;
    ready_style <= ready_style_e'($urandom_range(0, 3));
    quiet_sender = ($urandom_range(0, 3) == 0);
  endtask

  // Fresh from reset the unit is stopped and a button press is ignored
  // unless the unit is the left end of the chain.
  task automatic test_idle_after_reset();
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // The left end starts on the button, but only once after reset.
  task automatic test_button_start();
    configure(8'd0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Both neighbour triggers at once: the right one wins and the scan heads left.
  task automatic test_trigger_priority();
    send_tick(1'b0, 1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // With the divider at its top value no animation step ever happens.
  task automatic test_divider_max();
    configure(8'd255, 1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // Long scans with rare triggers and button presses plus a little noise.
  // The first tick kicks a scan so the phase does not sit idle.
  task automatic run_scan_traffic(input int n_items);
    int   r;
    logic b;
    logic fl;
    logic fr;
    if ($urandom_range(0, 1) == 0) send_tick(1'b0, 1'b1, 1'b0);
    else send_tick(1'b0, 1'b0, 1'b1);
    for (int k = 1; k < n_items; k++) begin
      r = $urandom_range(0, 999);
      b = 1'b0;
      fl = 1'b0;
      fr = 1'b0;
      if (r < 3) fl = 1'b1;
      else if (r < 6) fr = 1'b1;
      else if (r < 7) {fr, fl} = 2'b11;
      else if (r < 20) b = 1'b1;
      else if (r < 23) {fr, fl, b} = 3'($urandom_range(0, 7));
      send_tick(b, fl, fr);
    end
  endtask

  // Hand-off to neighbours: no soft bounce, scans leave the bar at ends that hand over.
  task automatic test_hand_off();
    configure(8'd0, 1'b1, 1'b0, 1'b1, 1'b0);
    run_scan_traffic(160);
    configure(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    run_scan_traffic(160);
    configure(8'd2, 1'b1, 1'b0, 1'b0, 1'b0);
    run_scan_traffic(160);
    configure(8'd0, 1'b1, 1'b0, 1'b1, 1'b1);
    run_scan_traffic(160);
  endtask

  // Soft bounce at chain ends, including the single-unit chain.
  task automatic test_soft_bounce();
    configure(8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
    run_scan_traffic(160);
    configure(8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
    run_scan_traffic(160);
    configure(8'd0, 1'b1, 1'b1, 1'b0, 1'b1);
    run_scan_traffic(160);
    configure(8'd0, 1'b0, 1'b1, 1'b1, 1'b1);
    run_scan_traffic(160);
  endtask

  // Random register settings; a few phases use a slow prescaler.
  task automatic test_random_settings();
    logic [7:0] div;
    for (int p = 0; p < 4; p++) begin
      div = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255))
                                        : 8'($urandom_range(0, 1));
      configure(div, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_scan_traffic(160);
    end
  endtask

  initial begin
    int drain_cycles;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_button_start();
    test_trigger_priority();
    test_divider_max();
    test_hand_off();
    test_soft_bounce();
    test_random_settings();
    s_axis_tvalid_i <= 1'b0;
    drain_cycles = 0;
    while (pending_frames.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (IdlePause * 2) @(posedge clk_i);
    if (failures == 0 && pending_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // About 2000 ticks with sender gaps and long receiver stalls finish well before this
  // watchdog fires.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
